[design/memory_address_pattern_tester_core_assert.svh]
// Assertion macros for the memory address pattern tester checker.
// Needs signals clock and reset in the scope of each use.
`ifndef MEMORY_ADDRESS_PATTERN_TESTER_CORE_ASSERT_SVH
`define MEMORY_ADDRESS_PATTERN_TESTER_CORE_ASSERT_SVH

// Hold prop at every clock edge outside reset.
`define MAPT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Require cons in the cycle after ante.
`define MAPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/mapt_pkg.sv]
// Shared types, codes and helpers for the memory address pattern tester.
// No dependencies.
package mapt_pkg;

   localparam int DEPTH_DEFAULT       = 1024;
   localparam int MAX_REPORTS_DEFAULT = 63;

   localparam int WORD_W   = 64;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int LEVEL_W  = 2;
   localparam int STATUS_W = 3;
   localparam int MODE_W   = 2;
   localparam int REPS_W   = 6;

   localparam logic [COUNT_W-1:0] WORDS_RESET = 11'd1024;

   localparam logic [MODE_W-1:0] MODE_FILL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MEMERR   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REPORT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SUMMARY  = 3'd4;

   localparam logic [LEVEL_W-1:0] LVL_NONE     = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_NOTFOUND = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_MEMERR   = 2'd2;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [COUNT_W-1:0]  error_count;
      logic [LEVEL_W-1:0]  error_level;
      logic                last;
   } mapt_rsp_type;

   function automatic logic [LEVEL_W-1:0] level_max(input logic [LEVEL_W-1:0] a,
                                                    input logic [LEVEL_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic mapt_rsp_type make_rsp(input logic [STATUS_W-1:0] status,
                                             input logic [INDEX_W-1:0]  index,
                                             input logic [COUNT_W-1:0]  count,
                                             input logic [LEVEL_W-1:0]  level,
                                             input logic                last);
      mapt_rsp_type r;
      r.valid       = 1'b1;
      r.status      = status;
      r.index       = index;
      r.error_count = count;
      r.error_level = level;
      r.last        = last;
      return r;
   endfunction

endpackage

[design/mapt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mapt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mapt_engine.sv]
// Test sequencer: fill, single write, linear check and binary search over the word RAM.
// Depends on mapt_pkg; drives the ports of one mapt_ram.
module mapt_engine #(
   parameter int DEPTH       = mapt_pkg::DEPTH_DEFAULT,
   parameter int MAX_REPORTS = mapt_pkg::MAX_REPORTS_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = AW + 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [mapt_pkg::MODE_W-1:0]           mode,
   input  logic [mapt_pkg::INDEX_W-1:0]          address,
   input  logic [mapt_pkg::WORD_W-1:0]           data,
   input  logic [CW-1:0]                         words,
   input  logic                                  filled_clr,
   output logic                                  ram_wr_en,
   output logic [AW-1:0]                         ram_wr_addr,
   output logic [mapt_pkg::WORD_W-1:0]           ram_wr_data,
   output logic                                  ram_rd_en,
   output logic [AW-1:0]                         ram_rd_addr,
   input  logic [mapt_pkg::WORD_W-1:0]           ram_rd_data,
   output mapt_pkg::mapt_rsp_type                rsp
);
   import mapt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_FILL,
      S_CHECK,
      S_PROBE,
      S_COMPARE
   } state_type;

   state_type           state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [INDEX_W-1:0]  addr_ff, addr_in;
   logic [WORD_W-1:0]   data_ff, data_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                pv_ff, pv_in;
   logic [AW-1:0]       pidx_ff, pidx_in;
   logic [CW-1:0]       low_ff, low_in;
   logic [CW-1:0]       end_ff, end_in;
   logic [AW-1:0]       mid_ff, mid_in;
   logic [COUNT_W-1:0]  errs_ff, errs_in;
   logic [REPS_W-1:0]   reps_ff, reps_in;
   logic                filled_ff, filled_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   mapt_rsp_type        rsp_ff, rsp_in;
   logic [CW-1:0]       mid_calc;

   assign mid_calc = low_ff + ((end_ff - CW'(1) - low_ff) >> 1);

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      addr_in     = addr_ff;
      data_in     = data_ff;
      cnt_in      = cnt_ff;
      pv_in       = pv_ff;
      pidx_in     = pidx_ff;
      low_in      = low_ff;
      end_in      = end_ff;
      mid_in      = mid_ff;
      errs_in     = errs_ff;
      reps_in     = reps_ff;
      filled_in   = filled_ff;
      level_in    = level_ff;
      rsp_in      = rsp_ff;
      rsp_in.valid = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff[AW-1:0];
      ram_wr_data = WORD_W'(cnt_ff);
      ram_rd_en   = 1'b0;
      ram_rd_addr = cnt_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = mode;
               addr_in = address;
               data_in = data;
               cnt_in  = '0;
               pv_in   = 1'b0;
               errs_in = '0;
               reps_in = '0;
               low_in  = '0;
               end_in  = words;
               case (mode)
                  MODE_FILL:  state_in = S_FILL;
                  MODE_WRITE: state_in = S_WRITE;
                  MODE_CHECK: state_in = filled_ff ? S_CHECK : S_FILL;
                  default:    state_in = filled_ff ? S_PROBE : S_FILL;
               endcase
            end
         end
         S_WRITE: begin
            if (32'(addr_ff) < 32'(DEPTH)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(addr_ff);
               ram_wr_data = data_ff;
            end
            rsp_in   = make_rsp(ST_OK, '0, '0, level_ff, 1'b1);
            state_in = S_IDLE;
         end
         S_FILL: begin
            ram_wr_en = 1'b1;
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == words - CW'(1)) begin
               filled_in = 1'b1;
               cnt_in    = '0;
               case (mode_ff)
                  MODE_FILL: begin
                     rsp_in   = make_rsp(ST_OK, '0, '0, level_ff, 1'b1);
                     state_in = S_IDLE;
                  end
                  MODE_CHECK: state_in = S_CHECK;
                  default:    state_in = S_PROBE;
               endcase
            end
         end
         S_CHECK: begin
            if (cnt_ff != words) begin
               ram_rd_en = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
               pv_in     = 1'b1;
               pidx_in   = cnt_ff[AW-1:0];
            end else begin
               pv_in = 1'b0;
            end
            if (pv_ff) begin
               if (ram_rd_data != WORD_W'(pidx_ff)) begin
                  errs_in  = (errs_ff == '1) ? errs_ff : errs_ff + COUNT_W'(1);
                  level_in = level_max(level_ff, LVL_MEMERR);
                  if (reps_ff < REPS_W'(MAX_REPORTS)) begin
                     reps_in = reps_ff + REPS_W'(1);
                     rsp_in  = make_rsp(ST_REPORT, INDEX_W'(pidx_ff), errs_in,
                                        level_in, 1'b0);
                  end
               end
            end else if (cnt_ff == words) begin
               rsp_in   = make_rsp(ST_SUMMARY, '0, errs_ff, level_ff, 1'b1);
               state_in = S_IDLE;
            end
         end
         S_PROBE: begin
            if (low_ff < end_ff) begin
               mid_in      = mid_calc[AW-1:0];
               ram_rd_en   = 1'b1;
               ram_rd_addr = mid_calc[AW-1:0];
               state_in    = S_COMPARE;
            end else begin
               level_in = level_max(level_ff, LVL_NOTFOUND);
               rsp_in   = make_rsp(ST_NOTFOUND, '0, '0, level_in, 1'b1);
               state_in = S_IDLE;
            end
         end
         S_COMPARE: begin
            if (ram_rd_data != WORD_W'(mid_ff)) begin
               level_in = level_max(level_ff, LVL_MEMERR);
               rsp_in   = make_rsp(ST_MEMERR, '0, '0, level_in, 1'b1);
               state_in = S_IDLE;
            end else if (ram_rd_data == data_ff) begin
               rsp_in   = make_rsp(ST_OK, INDEX_W'(mid_ff), '0, level_ff, 1'b1);
               state_in = S_IDLE;
            end else begin
               if (ram_rd_data < data_ff) begin
                  low_in = CW'(mid_ff) + CW'(1);
               end else begin
                  end_in = CW'(mid_ff);
               end
               state_in = S_PROBE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (filled_clr) begin
         filled_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
      pidx_ff <= pidx_in;
      low_ff  <= low_in;
      end_ff  <= end_in;
      mid_ff  <= mid_in;
      errs_ff <= errs_in;
      reps_ff <= reps_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         pv_ff     <= 1'b0;
         filled_ff <= 1'b0;
         level_ff  <= LVL_NONE;
         rsp_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         pv_ff     <= pv_in;
         filled_ff <= filled_in;
         level_ff  <= level_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp  = rsp_ff;

endmodule

[design/memory_address_pattern_tester_core.sv]
// Top level of the memory address pattern tester: word count register and wiring.
// Depends on mapt_pkg, mapt_ram and mapt_engine.
//
//   channel   signals                                  handshake
//   request   req_mode, req_address, req_data          start high, busy low
//   response  rsp_status, rsp_index, rsp_error_count,  rsp_valid, one cycle
//             rsp_error_level, rsp_last
//   control   csr_wr_data                              csr_wr_en
//
// Fill writes and check reads the clamped word count of words; search probes by
// binary search. Check and search run a fill pass first when the store is not
// filled. All reads go through the single RAM read port.
// Synchronous reset clears control; the word store stays undefined, no clearing pass.
// The response side cannot stall; busy holds off new requests until the last beat.
module memory_address_pattern_tester_core #(
   parameter int DEPTH       = mapt_pkg::DEPTH_DEFAULT,
   parameter int MAX_REPORTS = mapt_pkg::MAX_REPORTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [mapt_pkg::MODE_W-1:0]    req_mode,
   input  logic [mapt_pkg::INDEX_W-1:0]   req_address,
   input  logic [mapt_pkg::WORD_W-1:0]    req_data,
   output logic                           rsp_valid,
   output logic [mapt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mapt_pkg::INDEX_W-1:0]   rsp_index,
   output logic [mapt_pkg::COUNT_W-1:0]   rsp_error_count,
   output logic [mapt_pkg::LEVEL_W-1:0]   rsp_error_level,
   output logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [mapt_pkg::COUNT_W-1:0]   csr_wr_data
);
   import mapt_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = AW + 1;
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [COUNT_W-1:0] words_ff;
   logic [NW-1:0]      words_ext;
   logic [CW-1:0]      words_used;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [WORD_W-1:0]  ram_rd_data;
   mapt_rsp_type       rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= WORDS_RESET;
      end else if (csr_wr_en) begin
         words_ff <= csr_wr_data;
      end
   end

   // clamp the word count to one through the store depth
   assign words_ext  = NW'(words_ff);
   assign words_used = (words_ff == '0)           ? CW'(1) :
                       (words_ext > NW'(DEPTH))   ? CW'(DEPTH) : CW'(words_ext);

   mapt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mapt_engine #(
      .DEPTH       (DEPTH),
      .MAX_REPORTS (MAX_REPORTS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .mode        (req_mode),
      .address     (req_address),
      .data        (req_data),
      .words       (words_used),
      .filled_clr  (csr_wr_en),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp         (rsp)
   );

   assign rsp_valid       = rsp.valid;
   assign rsp_status      = rsp.status;
   assign rsp_index       = rsp.index;
   assign rsp_error_count = rsp.error_count;
   assign rsp_error_level = rsp.error_level;
   assign rsp_last        = rsp.last;

endmodule

[design/mapt_checker.sv]
// Port-level assertions for the memory address pattern tester, bound to the top level.
// Depends on mapt_pkg and memory_address_pattern_tester_core_assert.svh.
`include "memory_address_pattern_tester_core_assert.svh"

module mapt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [mapt_pkg::STATUS_W-1:0]  rsp_status,
   input logic [mapt_pkg::LEVEL_W-1:0]   rsp_error_level,
   input logic                           rsp_last
);
   import mapt_pkg::*;

   `MAPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `MAPT_ASSERT(a_report_not_last, (rsp_valid && rsp_status == ST_REPORT) |-> !rsp_last, "report marked last")
   `MAPT_ASSERT(a_mid_busy, (rsp_valid && !rsp_last) |-> busy, "intermediate beat while idle")
   `MAPT_ASSERT(a_last_idle, (rsp_valid && rsp_last) |-> !busy, "final beat while still busy")
   `MAPT_ASSERT(a_memerr_level, (rsp_valid && rsp_status == ST_MEMERR) |-> (rsp_error_level == LVL_MEMERR), "memory error without level")

endmodule

bind memory_address_pattern_tester_core mapt_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_error_level (rsp_error_level),
   .rsp_last        (rsp_last)
);
